// ===== rtl/tcsf_pkg.sv =====
`timescale 1ns / 1ps
package tcsf_pkg;

  localparam int TEMP_W = 12;
  localparam int VOLT_W = 16;
  localparam int CFG_W = 32;
  localparam int DIV_Q_W = 11;

  localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [1:0] CFG_OFFSET_MV = 2'd1;
  localparam logic [1:0] CFG_GAIN_Q16 = 2'd2;

  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_MA4 = 3'd1;
  localparam logic [2:0] MODE_MA8 = 3'd2;
  localparam logic [2:0] MODE_MA16 = 3'd3;
  localparam logic [2:0] MODE_EMA1 = 3'd4;
  localparam logic [2:0] MODE_EMA3 = 3'd6;

  localparam logic [15:0] VOLT_MIN_Q4 = 16'd800;
  localparam logic [15:0] VOLT_MAX_Q4 = 16'd52000;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic eval;
    logic sum_step;
    logic avg_prep;
    logic avg_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic sum_last;
    logic go_ma;
  } sts_t;

endpackage

// ===== rtl/tcsf_in_if.sv =====
`timescale 1ns / 1ps
interface tcsf_in_if;
  logic valid;
  logic ready;
  logic [15:0] voltage_q4;
  modport source(output valid, output voltage_q4, input ready);
  modport sink(input valid, input voltage_q4, output ready);
endinterface

// ===== rtl/tcsf_out_if.sv =====
`timescale 1ns / 1ps
interface tcsf_out_if;
  logic valid;
  logic ready;
  logic signed [11:0] temp_tenths;
  logic temp_valid;
  modport source(output valid, output temp_tenths, output temp_valid, input ready);
  modport sink(input valid, input temp_tenths, input temp_valid, output ready);
endinterface

// ===== rtl/tcsf_ram.sv =====
`timescale 1ns / 1ps
module tcsf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// ===== rtl/tcsf_ctrl.sv =====
`timescale 1ns / 1ps
module tcsf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tcsf_pkg::sts_t   sts,
  output tcsf_pkg::cmd_t   cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_EVAL, S_SUM, S_AVGP, S_AVGD, S_AVGF, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = sts.go_ma ? S_SUM : S_OUT;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) state_nxt = S_AVGP;
      end
      S_AVGP: begin
        cmd.avg_prep = 1'b1;
        state_nxt = S_AVGD;
      end
      S_AVGD: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_AVGF;
      end
      S_AVGF: begin
        cmd.avg_fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The output register may still hold the previous item.
        if (!out_valid_r || out_ready) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== rtl/tcsf_dp.sv =====
`timescale 1ns / 1ps
module tcsf_dp #(
  parameter int MA_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcsf_pkg::cmd_t      cmd,
  output tcsf_pkg::sts_t      sts,
  input  logic [15:0]         in_voltage_q4,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output logic signed [11:0]  out_temp_tenths,
  output logic                out_temp_valid
);
  localparam int PW = $clog2(MA_DEPTH);
  localparam int CW = $clog2(MA_DEPTH + 1);
  localparam int SW = tcsf_pkg::TEMP_W + CW;
  localparam int QW = tcsf_pkg::DIV_Q_W;

  // Configuration registers.
  logic [2:0]         mode_r;
  logic [15:0]        offset_r;
  logic signed [31:0] gain_r;

  // Filter state.
  logic               locked_r, locked_nxt;
  logic [1:0]         startup_r, startup_nxt;
  logic [2:0]         err_r, err_nxt;
  logic signed [11:0] last_r, last_nxt;
  logic signed [11:0] held_r, held_nxt;
  logic               held_v_r, held_v_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               full_r, full_nxt;
  logic signed [11:0] ema_r, ema_nxt;
  logic               emas_r, emas_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  // Working registers.
  logic [15:0]        v_r;
  logic [31:0]        rem_r;
  logic [QW+30:0]     dsh_r;
  logic [QW-1:0]      q_r;
  logic [3:0]         step_r;
  logic               ovf_r, neg_r, anz_r, vok_r, aneg_r;
  logic [31:0]        ag_r;
  logic signed [SW-1:0] acc_r;
  logic [CW-1:0]      sidx_r;
  logic signed [11:0] pend_t_r, pend_t_nxt;
  logic               pend_v_r, pend_v_nxt;

  // Conversion operands.
  logic signed [21:0] vdiff;
  logic [19:0]        vmag;
  logic [31:0]        an, ag;
  logic signed [32:0] gx;
  logic               gain_small;

  assign vdiff = $signed({6'b0, v_r}) - $signed({2'b0, offset_r, 4'b0});
  assign vmag = vdiff[21] ? 20'(-vdiff) : 20'(vdiff);
  assign an = {vmag, 12'b0};
  assign gx = {gain_r[31], gain_r};
  assign ag = gx[32] ? 32'(-gx) : 32'(gx);
  assign gain_small = (gain_r >= -32'sd6) && (gain_r <= 32'sd6);

  // Conversion result once the quotient is complete.
  logic               rnd, range_bad, rv;
  logic [11:0]        mag12;
  logic signed [11:0] raw;

  assign rnd = {rem_r, 1'b0} >= {1'b0, ag_r};
  always_comb begin
    if (neg_r) begin
      range_bad = ovf_r || (q_r > QW'(400)) || ((q_r == QW'(400)) && (rem_r != '0));
    end else begin
      range_bad = ovf_r || (q_r > QW'(1500)) || ((q_r == QW'(1500)) && (rem_r != '0));
    end
  end
  assign rv = vok_r && (anz_r || !range_bad);
  assign mag12 = anz_r ? 12'd0 : (12'(q_r) + 12'(rnd));
  assign raw = neg_r ? -$signed(mag12) : $signed(mag12);

  // Ring memory.
  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [11:0]        ram_rdata;

  tcsf_ram #(.WIDTH(tcsf_pkg::TEMP_W), .DEPTH(MA_DEPTH)) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (raw),
    .raddr   (sidx_r[PW-1:0]),
    .rdata_r (ram_rdata)
  );

  // Per-item decision: lock machine, EMA and ring update.
  logic signed [12:0] jump;
  logic               far, filt, go_ma;
  logic [1:0]         sft;
  logic signed [13:0] ed, ed_adj, ed_q;
  int                 win_i;
  logic [CW-1:0]      win, pn;
  logic [PW-1:0]      pw;

  assign jump = {raw[11], raw} - {last_r[11], last_r};
  assign far = (jump > 13'sd200) || (jump < -13'sd200);

  always_comb begin
    locked_nxt = locked_r;
    startup_nxt = startup_r;
    err_nxt = err_r;
    last_nxt = last_r;
    held_nxt = held_r;
    held_v_nxt = held_v_r;
    pos_nxt = pos_r;
    full_nxt = full_r;
    ema_nxt = ema_r;
    emas_nxt = emas_r;
    count_nxt = count_r;
    pend_v_nxt = 1'b0;
    pend_t_nxt = '0;
    filt = 1'b0;
    ram_we = 1'b0;
    ram_waddr = '0;
    go_ma = 1'b0;
    sft = 2'(mode_r - 3'd3);
    ed = '0;
    ed_adj = '0;
    ed_q = '0;
    win_i = 4;
    win = '0;
    pn = '0;
    pw = '0;
    if (gain_small) begin
      // Gain too close to zero: invalid and no state change.
    end else if (mode_r == tcsf_pkg::MODE_PASS) begin
      pend_v_nxt = rv;
      pend_t_nxt = rv ? raw : 12'sd0;
    end else begin
      if (!locked_r) begin
        if (!rv) begin
          startup_nxt = 2'd0;
        end else if (startup_r == 2'd0) begin
          last_nxt = raw;
          startup_nxt = 2'd1;
        end else if (!far) begin
          startup_nxt = startup_r + 2'd1;
          last_nxt = raw;
          if (startup_r == 2'd2) begin
            locked_nxt = 1'b1;
            err_nxt = 3'd0;
            pos_nxt = '0;
            full_nxt = 1'b0;
            emas_nxt = 1'b0;
            filt = 1'b1;
          end
        end else begin
          last_nxt = raw;
          startup_nxt = 2'd1;
        end
      end else if (!rv || far) begin
        err_nxt = err_r + 3'd1;
        if (err_r == 3'd4) begin
          locked_nxt = 1'b0;
          startup_nxt = 2'd0;
          if (rv) begin
            last_nxt = raw;
            startup_nxt = 2'd1;
          end
        end else begin
          pend_v_nxt = held_v_r;
          pend_t_nxt = held_v_r ? held_r : 12'sd0;
        end
      end else begin
        err_nxt = 3'd0;
        last_nxt = raw;
        filt = 1'b1;
      end

      if (filt) begin
        if ((mode_r >= tcsf_pkg::MODE_EMA1) && (mode_r <= tcsf_pkg::MODE_EMA3)) begin
          if (!emas_nxt) begin
            ema_nxt = raw;
            emas_nxt = 1'b1;
          end else begin
            ed = 14'(raw) - 14'(ema_r);
            // Bias negative differences so the shift truncates toward zero.
            ed_adj = ed + (ed[13] ? ((14'sd1 <<< sft) - 14'sd1) : 14'sd0);
            ed_q = ed_adj >>> sft;
            ema_nxt = ema_r + 12'(ed_q);
          end
          held_nxt = ema_nxt;
          held_v_nxt = 1'b1;
          pend_v_nxt = 1'b1;
          pend_t_nxt = ema_nxt;
        end else begin
          if (mode_r == tcsf_pkg::MODE_MA8) win_i = 8;
          else if (mode_r == tcsf_pkg::MODE_MA16) win_i = 16;
          if (win_i > MA_DEPTH) win_i = MA_DEPTH;
          win = CW'(win_i);
          pw = (CW'(pos_nxt) >= win) ? '0 : pos_nxt;
          pn = CW'(pw) + CW'(1);
          ram_we = cmd.eval;
          ram_waddr = pw;
          if (pn >= win) begin
            pos_nxt = '0;
            full_nxt = 1'b1;
          end else begin
            pos_nxt = pn[PW-1:0];
          end
          count_nxt = full_nxt ? win : pn;
          if (count_nxt == '0) count_nxt = CW'(1);
          go_ma = 1'b1;
        end
      end
    end
  end

  // Configuration writes that change a value clear the filter.
  logic [2:0]         cfg_mode;
  logic [15:0]        cfg_off;
  logic signed [32:0] gdiff;
  logic               cfg_clear;

  assign cfg_mode = cfg_wdata[2:0];
  assign cfg_off = cfg_wdata[15:0];
  assign gdiff = $signed({cfg_wdata[31], cfg_wdata}) - $signed({gain_r[31], gain_r});

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        tcsf_pkg::CFG_FILTER_MODE: cfg_clear = (cfg_mode != mode_r);
        tcsf_pkg::CFG_OFFSET_MV:   cfg_clear = (cfg_off != offset_r);
        tcsf_pkg::CFG_GAIN_Q16:    cfg_clear = (gdiff > 33'sd6) || (gdiff < -33'sd6);
        default:                   cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tcsf_pkg::MODE_PASS;
      offset_r <= '0;
      gain_r <= '0;
    end else if (cfg_clear) begin
      case (cfg_index)
        tcsf_pkg::CFG_FILTER_MODE: mode_r <= cfg_mode;
        tcsf_pkg::CFG_OFFSET_MV:   offset_r <= cfg_off;
        default:                   gain_r <= cfg_wdata;
      endcase
    end
  end

  // Average: magnitude of the ring sum, then sign.
  logic signed [SW-1:0] amag;
  logic [QW-1:0]        aq;
  logic signed [11:0]   avg;

  assign amag = acc_r[SW-1] ? -acc_r : acc_r;
  assign aq = q_r;
  assign avg = aneg_r ? -$signed(12'(aq)) : $signed(12'(aq));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      locked_r <= 1'b0;
      startup_r <= '0;
      err_r <= '0;
      last_r <= '0;
      held_r <= '0;
      held_v_r <= 1'b0;
      pos_r <= '0;
      full_r <= 1'b0;
      ema_r <= '0;
      emas_r <= 1'b0;
      count_r <= CW'(1);
    end else if (cmd.eval) begin
      locked_r <= locked_nxt;
      startup_r <= startup_nxt;
      err_r <= err_nxt;
      last_r <= last_nxt;
      held_r <= held_nxt;
      held_v_r <= held_v_nxt;
      pos_r <= pos_nxt;
      full_r <= full_nxt;
      ema_r <= ema_nxt;
      emas_r <= emas_nxt;
      count_r <= count_nxt;
    end else if (cmd.avg_fin) begin
      held_r <= avg;
      held_v_r <= 1'b1;
    end
  end

  // Shared restoring divider and working registers.
  logic [QW+30:0] rem_x;
  assign rem_x = (QW+31)'(rem_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= in_voltage_q4;
    end
    if (cmd.prep) begin
      rem_r <= an;
      dsh_r <= {ag, (QW-1)'(0)};
      q_r <= '0;
      step_r <= '0;
      ovf_r <= {(QW)'(0), an} >= {ag, (QW)'(0)};
      neg_r <= vdiff[21] ^ gain_r[31];
      anz_r <= (an == '0);
      vok_r <= (v_r >= tcsf_pkg::VOLT_MIN_Q4) && (v_r <= tcsf_pkg::VOLT_MAX_Q4);
      ag_r <= ag;
    end else if (cmd.avg_prep) begin
      rem_r <= 32'(unsigned'(amag));
      dsh_r <= {32'(count_r), (QW-1)'(0)};
      q_r <= '0;
      step_r <= '0;
      aneg_r <= acc_r[SW-1];
    end else if (cmd.div_step) begin
      if (rem_x >= dsh_r) begin
        rem_r <= rem_r - dsh_r[31:0];
        q_r <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r <= {q_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      step_r <= step_r + 4'd1;
    end
    if (cmd.eval) begin
      acc_r <= '0;
      sidx_r <= '0;
    end else if (cmd.sum_step) begin
      // Read data is registered, so it belongs to the address of the step before.
      if (sidx_r != '0) acc_r <= acc_r + SW'($signed(ram_rdata));
      sidx_r <= sidx_r + CW'(1);
    end
    // At the end of an average the pending result comes from the divider.
    if (cmd.eval) begin
      pend_v_r <= pend_v_nxt;
      pend_t_r <= pend_t_nxt;
    end else if (cmd.avg_fin) begin
      pend_v_r <= 1'b1;
      pend_t_r <= avg;
    end
    if (cmd.emit) begin
      out_temp_valid <= pend_v_r;
      out_temp_tenths <= pend_t_r;
    end
  end

  always_comb begin
    sts.div_last = (step_r == 4'(QW - 1));
    sts.sum_last = (sidx_r == count_r);
    sts.go_ma = go_ma;
  end
endmodule

// ===== rtl/temp_sensor_convert_and_filter.sv =====
`timescale 1ns / 1ps
// Converts sensor voltage samples to tenths of a degree through the offset and
// gain registers, then passes them through or guards them with a lock machine
// and smooths them by a moving average or an EMA, one result item per input
// item. A conversion runs through the 11-step shared restoring divider; a
// moving average over N filled ring entries then sums the ring memory, read one
// entry per cycle, and divides the sum in the same divider. The next item is
// accepted once the current one has moved into the output register. There is
// no clearing pass after reset.
module temp_sensor_convert_and_filter #(
  parameter int MA_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tcsf_in_if.sink     in_ch,
  tcsf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  tcsf_pkg::cmd_t cmd;
  tcsf_pkg::sts_t sts;

  tcsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcsf_dp #(.MA_DEPTH(MA_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_voltage_q4   (in_ch.voltage_q4),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_temp_tenths (out_ch.temp_tenths),
    .out_temp_valid  (out_ch.temp_valid)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote an item not yet taken");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.temp_valid) |-> (out_ch.temp_tenths == 12'sd0))
    else $error("invalid item carries a nonzero temperature");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.temp_valid) |->
      (out_ch.temp_tenths >= -12'sd400 && out_ch.temp_tenths <= 12'sd1500))
    else $error("valid temperature out of range");
endmodule

// ===== sim/temp_sensor_convert_and_filter_test.sv =====
`timescale 1ns / 1ps
module temp_sensor_convert_and_filter_test;

  typedef struct {
    logic signed [tcsf_pkg::TEMP_W-1:0] temp_tenths;
    logic                               temp_valid;
  } temp_reading_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;

  tcsf_in_if in_ch();
  tcsf_out_if out_ch();

  temp_sensor_convert_and_filter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Mirror of the block's registers and filter state.
  logic [2:0] cur_mode;
  logic [15:0] cur_offset;
  int cur_gain;
  bit trk_locked;
  int trk_startup;
  int trk_errors;
  int trk_last_raw;
  int trk_held;
  bit trk_held_valid;
  int avg_ring[16];
  int ring_pos;
  bit ring_full;
  int ema_val;
  bit ema_started;

  temp_reading_t pending_temps[$];
  int failures = 0;
  int items_sent = 0;
  int temps_checked = 0;
  int valid_temps = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void clear_tracking();
    trk_locked = 0;
    trk_startup = 0;
    trk_errors = 0;
    trk_last_raw = 0;
    trk_held = 0;
    trk_held_valid = 0;
    foreach (avg_ring[i]) avg_ring[i] = 0;
    ring_pos = 0;
    ring_full = 0;
    ema_val = 0;
    ema_started = 0;
  endfunction

  function automatic void apply_register_write(logic [1:0] idx, logic [31:0] data);
    longint diff;
    if (idx == tcsf_pkg::CFG_FILTER_MODE) begin
      if (data[2:0] != cur_mode) begin
        clear_tracking();
        cur_mode = data[2:0];
      end
    end else if (idx == tcsf_pkg::CFG_OFFSET_MV) begin
      if (data[15:0] != cur_offset) begin
        clear_tracking();
        cur_offset = data[15:0];
      end
    end else if (idx == tcsf_pkg::CFG_GAIN_Q16) begin
      diff = longint'($signed(data)) - longint'(cur_gain);
      if (diff > 6 || diff < -6) begin
        clear_tracking();
        cur_gain = $signed(data);
      end
    end
  endfunction

  function automatic bit convert_voltage(logic [15:0] vq4, output int t);
    longint num, g, an, ag, a, r, mag;
    bit neg;
    t = 0;
    if (vq4 < tcsf_pkg::VOLT_MIN_Q4 || vq4 > tcsf_pkg::VOLT_MAX_Q4) return 0;
    num = (longint'(vq4) - longint'(cur_offset) * 16) * 4096;
    g = cur_gain;
    neg = (num < 0) != (g < 0);
    an = (num < 0) ? -num : num;
    ag = (g < 0) ? -g : g;
    if (an == 0) return 1;
    a = an / ag;
    r = an % ag;
    if (neg && (a > 400 || (a == 400 && r != 0))) return 0;
    if (!neg && (a > 1500 || (a == 1500 && r != 0))) return 0;
    mag = a + ((2 * r >= ag) ? 1 : 0);
    t = neg ? -int'(mag) : int'(mag);
    return 1;
  endfunction

  function automatic temp_reading_t make_reading(bit v, int t);
    temp_reading_t rd;
    rd.temp_valid = v;
    rd.temp_tenths = v ? t[tcsf_pkg::TEMP_W-1:0] : '0;
    return rd;
  endfunction

  function automatic temp_reading_t predict_temperature(logic [15:0] vq4);
    int raw, diff, window, count, sum;
    bit rv;
    if (cur_gain >= -6 && cur_gain <= 6) return make_reading(0, 0);
    rv = convert_voltage(vq4, raw);
    if (cur_mode == tcsf_pkg::MODE_PASS) return make_reading(rv, raw);
    diff = raw - trk_last_raw;
    if (diff < 0) diff = -diff;
    if (!trk_locked) begin
      if (!rv) begin
        trk_startup = 0;
        return make_reading(0, 0);
      end
      if (trk_startup == 0) begin
        trk_startup = 1;
      end else if (diff <= 200) begin
        trk_startup++;
        if (trk_startup >= 3) begin
          trk_locked = 1;
          trk_errors = 0;
          ring_pos = 0;
          ring_full = 0;
          ema_started = 0;
        end
      end else begin
        trk_startup = 1;
      end
      trk_last_raw = raw;
      if (!trk_locked) return make_reading(0, 0);
    end else begin
      if (!rv || diff > 200) begin
        trk_errors++;
        if (trk_errors >= 5) begin
          // Too many rejected samples in a row: drop the lock and restart search.
          trk_locked = 0;
          trk_startup = 0;
          if (rv) begin
            trk_last_raw = raw;
            trk_startup = 1;
          end
          return make_reading(0, 0);
        end
        return make_reading(trk_held_valid, trk_held);
      end
      trk_errors = 0;
      trk_last_raw = raw;
    end
    if (cur_mode >= tcsf_pkg::MODE_EMA1 && cur_mode <= tcsf_pkg::MODE_EMA3) begin
      if (!ema_started) begin
        ema_val = raw;
        ema_started = 1;
      end else begin
        ema_val = ema_val + (raw - ema_val) / (1 << (cur_mode - 3));
      end
      trk_held = ema_val;
    end else begin
      window = (cur_mode == tcsf_pkg::MODE_MA8) ? 8 :
               (cur_mode == tcsf_pkg::MODE_MA16) ? 16 : 4;
      if (ring_pos >= window) ring_pos = 0;
      avg_ring[ring_pos] = raw;
      ring_pos++;
      if (ring_pos >= window) begin
        ring_pos = 0;
        ring_full = 1;
      end
      count = ring_full ? window : ring_pos;
      if (count == 0) count = 1;
      sum = 0;
      for (int i = 0; i < count; i++) sum += avg_ring[i];
      trk_held = sum / count;
    end
    trk_held_valid = 1;
    return make_reading(1, trk_held);
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    temp_reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_temps.size() == 0) begin
        $error("temperature item with no item outstanding: temp_tenths %0d temp_valid %0b",
               out_ch.temp_tenths, out_ch.temp_valid);
        failures++;
      end else begin
        want = pending_temps.pop_front();
        temps_checked++;
        if (out_ch.temp_valid) valid_temps++;
        if (out_ch.temp_tenths !== want.temp_tenths) begin
          $error("temp_tenths expected %0d actual %0d", want.temp_tenths, out_ch.temp_tenths);
          failures++;
        end
        if (out_ch.temp_valid !== want.temp_valid) begin
          $error("temp_valid expected %0b actual %0b", want.temp_valid, out_ch.temp_valid);
          failures++;
        end
      end
    end
  end

  task automatic send_sample(logic [15:0] vq4);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid = 1'b1;
    in_ch.voltage_q4 = vq4;
    do @(posedge clk); while (!in_ch.ready);
    pending_temps.push_back(predict_temperature(vq4));
    items_sent++;
    @(negedge clk);
  endtask

  // Lets every outstanding item come back, then covers the longest moving average.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_temps.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    drain_results();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_register_write(idx, data);
  endtask

  task automatic test_conversion_edges();
    write_register(tcsf_pkg::CFG_FILTER_MODE, tcsf_pkg::MODE_PASS);
    write_register(tcsf_pkg::CFG_GAIN_Q16, 32'd196608);
    send_sample(16'd0);
    send_sample(16'd799);
    send_sample(16'd800);
    send_sample(16'd52000);
    send_sample(16'd52001);
    send_sample(16'hFFFF);
    // Exact halves must round away from zero on both signs.
    write_register(tcsf_pkg::CFG_GAIN_Q16, 32'd131072);
    send_sample(16'd816);
    write_register(tcsf_pkg::CFG_OFFSET_MV, 32'd100);
    send_sample(16'd816);
    // A gain write within six counts is dropped; the index past the last does nothing.
    write_register(tcsf_pkg::CFG_GAIN_Q16, 32'd131076);
    write_register(2'd3, 32'hFFFF_FFFF);
    send_sample(16'd1600);
    write_register(tcsf_pkg::CFG_GAIN_Q16, 32'd6);
    send_sample(16'd1600);
    write_register(tcsf_pkg::CFG_GAIN_Q16, -32'sd6);
    send_sample(16'd1600);
  endtask

  task automatic test_lock_and_hold();
    int volts_mv[12] = '{100, 150, 250, 260, 900, 0, 270, 1000, 1000, 1000, 1000, 1000};
    write_register(tcsf_pkg::CFG_FILTER_MODE, tcsf_pkg::MODE_MA4);
    write_register(tcsf_pkg::CFG_OFFSET_MV, 32'd0);
    write_register(tcsf_pkg::CFG_GAIN_Q16, 32'd65536);
    foreach (volts_mv[i])
      send_sample(16'(volts_mv[i] * 16));
  endtask

  task automatic test_random_phases();
    int gain, mag, step, volt, pick;
    for (int phase = 0; phase < 28; phase++) begin
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      mag = $urandom_range(4 * 65536, 32768);
      gain = $urandom_range(1) ? mag : -mag;
      if (phase == 0) gain = 32'sh7FFF_FFFF;
      else if (phase == 1) gain = 32'sh8000_0000;
      else if (phase % 9 == 4) gain = $urandom_range(12) - 6;
      write_register(tcsf_pkg::CFG_FILTER_MODE, (phase == 27) ? 3'd7 : 3'(phase % 7));
      write_register(tcsf_pkg::CFG_OFFSET_MV, (phase == 2) ? 32'd65535 : $urandom_range(1500));
      write_register(tcsf_pkg::CFG_GAIN_Q16, gain);
      case (phase % 4)
        1: sender_idle_pct = 77;
        2: receiver_stall_pct = 77;
        3: begin
          sender_idle_pct = 13;
          receiver_stall_pct = 13;
        end
        default: ;
      endcase
      mag = (gain < 0) ? -gain : gain;
      step = int'((longint'(mag) * 3200) / 65536);
      if (step < 16) step = 16;
      if (step > 20000) step = 20000;
      volt = $urandom_range(52000, 800);
      for (int n = 0; n < 62; n++) begin
        pick = $urandom_range(99);
        if (phase == 5 && n == 30) drain_results();
        if (pick < 6) begin
          send_sample(16'($urandom));
        end else begin
          // Mostly small steps so the lock holds; some spikes to break it.
          if (pick < 14) volt += $urandom_range(1) ? 3 * step : -3 * step;
          else volt += $urandom_range(2 * step) - step;
          if (volt < 800) volt = 800;
          if (volt > 52000) volt = 52000;
          send_sample(16'(volt));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.voltage_q4 = '0;
    out_ch.ready = 1'b0;
    cur_mode = '0;
    cur_offset = '0;
    cur_gain = 0;
    clear_tracking();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_conversion_edges();
    test_lock_and_hold();
    test_random_phases();
    drain_results();
    $display("Sent %0d voltage items over all filter modes and idle patterns;", items_sent);
    $display("checked %0d temperature items, %0d of them valid.", temps_checked, valid_temps);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tcsf_pkg.sv
rtl/tcsf_in_if.sv
rtl/tcsf_out_if.sv
rtl/tcsf_ram.sv
rtl/tcsf_ctrl.sv
rtl/tcsf_dp.sv
rtl/temp_sensor_convert_and_filter.sv
sim/temp_sensor_convert_and_filter_test.sv
